// File: hdl/asa_pkg.sv
// Shared types and constants for the ADC scan averager.
// No dependencies; imported by adc_scan_averager_core.
`default_nettype none

package asa_pkg;

  // Channel count default and limits of the scan
  localparam int unsigned CHANNELS_DEF = 16;
  localparam int unsigned AVG_LIMIT    = 65000;
  localparam int unsigned DISCARD_END  = 5;
  localparam int unsigned FIRST_KEPT   = 4;

  // Divider: one quotient bit per step over the 32-bit accumulator
  localparam int unsigned DIV_STEPS    = 32;

  // Configuration port
  localparam int unsigned CFG_AW       = 4;
  localparam int unsigned CFG_DW       = 32;

  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_REFERENCE = 2'd1,
    REG_AVERAGE   = 2'd2
  } asa_reg_t;

  // Item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic [3:0]         channel;
    logic signed [15:0] write_value;
  } asa_in_t;

  typedef struct packed {
    logic               select_strobe;
    logic [3:0]         select_channel;
    logic [1:0]         select_reference;
    logic signed [15:0] read_data;
    logic [15:0]        changed_flags;
  } asa_out_t;

endpackage

`default_nettype wire

// File: hdl/adc_scan_averager_core.sv
// Round-robin ADC scanner with per-channel averaging and change flags.
// Depends on asa_pkg (payload structs, register indexes, constants).
//
// Each input beat is a scan tick (with the converter sample), a host read or a
// host write of a stored channel value; each beat yields exactly one result
// beat carrying the select command (if any), the read value and the change
// flags of the first sixteen channels. The block handles one item at a time:
// in_ready is high only while the sequencer is idle, and a new beat may be
// taken while the previous result still waits in the output register. With
// the output register free, a host access and most ticks pass through decode
// (S_EXEC) and the result load (S_DONE), after which the sequencer is idle and
// can take the next beat. The tick that closes an average also passes through
// the shared restoring divider (S_DIV, one quotient bit per cycle over the
// 32-bit sum) and sign fix-up (S_FIX) before the result load. Stored values
// and flags are cleared by reset directly; no clearing pass is needed.
`default_nettype none

module adc_scan_averager_core #(
  parameter int unsigned CHANNELS = asa_pkg::CHANNELS_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // input channel
  input  wire                        in_valid,
  output logic                       in_ready,
  input  asa_pkg::asa_in_t           in_data,
  // result channel
  output logic                       out_valid,
  input  wire                        out_ready,
  output asa_pkg::asa_out_t          out_data,
  // configuration port
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [asa_pkg::CFG_AW-1:0]  paddr,
  input  wire [asa_pkg::CFG_DW-1:0]  pwdata,
  output logic [asa_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import asa_pkg::*;

  localparam int unsigned POS_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(CHANNELS - 1);
  localparam int unsigned DCNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FIX,
    S_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic [15:0] enable_r;
  logic [31:0] reference_r;
  logic [15:0] average_r;

  // scan state
  logic [POS_W-1:0]  pos_r;
  logic [15:0]       cnt_r;
  logic signed [31:0] acc_r;
  logic signed [15:0] values_r [CHANNELS];
  logic [CHANNELS-1:0] flags_r;

  // working registers
  asa_in_t            item_r;
  logic signed [15:0] rd_r;
  logic               strobe_r;
  logic [3:0]         sel_ch_r;
  logic [1:0]         sel_ref_r;

  // divider
  logic [16:0]        div_r;
  logic [15:0]        rem_r;
  logic [31:0]        dq_r;
  logic               neg_r;
  logic [DCNT_W-1:0]  dcnt_r;

  // output register
  asa_out_t out_r;
  logic     out_valid_r;

  // ---- combinational helpers ----
  logic [15:0]        avg;
  logic [16:0]        cnt_limit;
  logic [15:0]        cnt_inc;
  logic [4:0]         pos5;
  logic               pos_en;
  logic [POS_W-1:0]   pos_next;
  logic               tick_sel;
  logic               tick_close;
  logic               ch_ok;
  logic [POS_W-1:0]   ch_idx;
  logic [POS_W-1:0]   rd_idx;
  logic [31:0]        acc_mag;
  logic [16:0]        rem_sh;
  logic               rem_ge;
  logic [15:0]        rem_nxt;
  logic [31:0]        dq_nxt;
  logic [31:0]        quo32;
  logic signed [15:0] quo;
  logic [15:0]        flag_word;
  logic               cfg_wr;

  assign avg       = (average_r > 16'(AVG_LIMIT)) ? 16'(AVG_LIMIT) : average_r;
  assign cnt_limit = {1'b0, avg} + 17'(DISCARD_END);
  assign cnt_inc   = cnt_r + 16'd1;

  assign pos5     = 5'(pos_r);
  assign pos_en   = (pos5 < 5'd16) && enable_r[pos5[3:0]];
  assign pos_next = (pos_r == POS_LAST) ? '0 : pos_r + POS_W'(1);

  // tick that selects a channel, tick that closes its average
  assign tick_sel   = (item_r.kind == KIND_TICK) && (cnt_r == 16'd0) && pos_en;
  assign tick_close = (item_r.kind == KIND_TICK) && (cnt_r != 16'd0) &&
                      ({1'b0, cnt_r} >= cnt_limit);

  assign ch_ok  = ({2'b00, item_r.channel} < 6'(CHANNELS));
  assign ch_idx = POS_W'(item_r.channel);
  assign rd_idx = (item_r.kind == KIND_TICK) ? pos_r : ch_idx;

  assign acc_mag = acc_r[31] ? 32'(-acc_r) : 32'(acc_r);

  // one restoring divider step
  assign rem_sh  = {rem_r, dq_r[31]};
  assign rem_ge  = (rem_sh >= div_r);
  assign rem_nxt = rem_ge ? 16'(rem_sh - div_r) : rem_sh[15:0];
  assign dq_nxt  = {dq_r[30:0], rem_ge};

  assign quo32 = neg_r ? (32'd0 - dq_r) : dq_r;
  assign quo   = signed'(quo32[15:0]);

  // change flags of the first sixteen channels
  for (genvar c = 0; c < 16; c++) begin : g_flag
    if (c < CHANNELS) begin : g_on
      assign flag_word[c] = flags_r[c];
    end else begin : g_off
      assign flag_word[c] = 1'b0;
    end
  end

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (asa_reg_t'(paddr[3:2]))
      REG_ENABLE:    prdata = {16'd0, enable_r};
      REG_REFERENCE: prdata = reference_r;
      REG_AVERAGE:   prdata = {16'd0, average_r};
      default:       prdata = '0;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---- sequencer, datapath and stored values ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= '0;
      reference_r <= '0;
      average_r   <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      acc_r       <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        values_r[i] <= '0;
      end
    end else begin
      // register writes
      if (cfg_wr) begin
        case (asa_reg_t'(paddr[3:2]))
          REG_ENABLE:    enable_r    <= pwdata[15:0];
          REG_REFERENCE: reference_r <= pwdata;
          REG_AVERAGE:   average_r   <= pwdata[15:0];
          default: ;
        endcase
      end

      // result beat taken; in S_DONE the next beat takes its place
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= S_EXEC;
          end
        end

        S_EXEC: begin
          rd_r      <= values_r[rd_idx];
          strobe_r  <= tick_sel;
          sel_ch_r  <= tick_sel ? pos5[3:0] : 4'd0;
          sel_ref_r <= tick_sel ? reference_r[{pos5[3:0], 1'b0} +: 2] : 2'd0;
          state_r   <= tick_close ? S_DIV : S_DONE;
          case (item_r.kind)
            KIND_TICK: begin
              if (cnt_r == 16'd0) begin
                if (!pos_en) begin
                  pos_r <= pos_next;
                end else begin
                  cnt_r <= 16'd1;
                  acc_r <= '0;
                end
              end else if ({1'b0, cnt_r} < cnt_limit) begin
                // settle samples are dropped, the rest summed
                cnt_r <= cnt_inc;
                if (cnt_inc > 16'(FIRST_KEPT)) begin
                  acc_r <= acc_r + 32'(item_r.sample);
                end
              end else begin
                // average complete: divide by avg+1
                div_r  <= {1'b0, avg} + 17'd1;
                rem_r  <= '0;
                dq_r   <= acc_mag;
                neg_r  <= acc_r[31];
                dcnt_r <= '0;
              end
            end
            KIND_READ: begin
              if (ch_ok) begin
                flags_r[ch_idx] <= 1'b0;
              end
            end
            KIND_WRITE: begin
              if (ch_ok) begin
                flags_r[ch_idx]  <= 1'b0;
                values_r[ch_idx] <= item_r.write_value;
              end
            end
            default: ;
          endcase
        end

        S_DIV: begin
          rem_r  <= rem_nxt;
          dq_r   <= dq_nxt;
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_FIX;
          end
        end

        S_FIX: begin
          // store on change and flag it, then move on; full quotient compared
          if (32'(rd_r) != quo32) begin
            values_r[pos_r] <= quo;
            flags_r[pos_r]  <= 1'b1;
          end
          cnt_r   <= '0;
          pos_r   <= pos_next;
          state_r <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_r.select_strobe    <= strobe_r;
            out_r.select_channel   <= sel_ch_r;
            out_r.select_reference <= sel_ref_r;
            out_r.read_data        <= (item_r.kind == KIND_READ && ch_ok) ? rd_r : '0;
            out_r.changed_flags    <= flag_word;
            out_valid_r            <= 1'b1;
            state_r                <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
